FILE: sv/tbd_pkg.sv
// ----------------------------------------------------------------------------
// Tagged block deframer package
// Shared constants, codes and the command record passed from front to back.
// ----------------------------------------------------------------------------
package tbd_pkg;

    // Stream format
    localparam int MAX_LENGTH_BYTES = 4;
    localparam int LEN_CNT_W        = $clog2(MAX_LENGTH_BYTES + 1);
    localparam int LEN_W            = 32;
    localparam int CNT_W            = 33;
    localparam logic [3:0] END_TYPE = 4'd4;

    // Configuration registers
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_TOTAL_BYTES = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_BLOCKS      = 1'd1;
    localparam logic [CFG_DATA_W-1:0]  MAX_TOTAL_RESET     = 32'd536870912;
    localparam logic [CFG_DATA_W-1:0]  MAX_BLOCKS_RESET    = 32'd20000000;

    // Input operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Result kinds
    localparam logic [2:0] KIND_PAYLOAD = 3'd0;
    localparam logic [2:0] KIND_EMPTY   = 3'd1;
    localparam logic [2:0] KIND_ENDMARK = 3'd2;
    localparam logic [2:0] KIND_OK      = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_TRUNC_LEN  = 2'd0;
    localparam logic [1:0] ERR_RANGE      = 2'd1;
    localparam logic [1:0] ERR_TOO_MANY   = 2'd2;
    localparam logic [1:0] ERR_NO_ENDMARK = 2'd3;

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Commands from the front parser to the back end
    typedef enum logic [2:0] {
        CMD_BLOCK   = 3'd0,  // block header done, length known
        CMD_BYTE    = 3'd1,  // one payload byte
        CMD_ENDMARK = 3'd2,  // end marker seen
        CMD_FAIL    = 3'd3,  // end of stream in a bad place
        CMD_OK      = 3'd4   // end of stream after end marker
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t          op;
        logic [3:0]       block_type;
        logic [LEN_W-1:0] data;       // block length, or payload byte in low bits
        logic             last;
        logic [1:0]       err;
    } cmd_t;

endpackage

FILE: sv/tbd_front.sv
// ----------------------------------------------------------------------------
// Tagged block deframer front end
// Parses markers and length fields into commands for headers, payload and ends.
// ----------------------------------------------------------------------------
module tbd_front
    import tbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       operation,
    input  logic [7:0] data_byte,
    output logic       cmd_valid,
    output cmd_t       cmd
);

    typedef enum logic [4:0] {
        PH_MARKER  = 5'b00001,
        PH_LENGTH  = 5'b00010,
        PH_PAYLOAD = 5'b00100,
        PH_ENDSEEN = 5'b01000,
        PH_HALT    = 5'b10000
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [3:0]           type_reg, type_next;
    logic [LEN_CNT_W-1:0] len_left_reg, len_left_next;
    logic [LEN_W-1:0]     acc_reg, acc_next;
    logic [LEN_W-1:0]     pay_left_reg, pay_left_next;

    logic [3:0]           code;
    logic                 start_blk;
    logic [LEN_W-1:0]     blk_len;

    assign code = data_byte[7:4];

    // Parser next state and command
    always_comb
    begin
        phase_next    = phase_reg;
        type_next     = type_reg;
        len_left_next = len_left_reg;
        acc_next      = acc_reg;
        pay_left_next = pay_left_reg;
        start_blk     = 1'b0;
        blk_len       = '0;
        cmd_valid     = 1'b0;
        cmd           = '{op: CMD_BYTE, block_type: type_reg, data: '0, last: 1'b0,
                          err: ERR_TRUNC_LEN};

        if (accept)
        begin
            if (operation == OP_END)
            begin
                unique case (phase_reg)
                    PH_MARKER:
                    begin
                        cmd_valid = 1'b1;
                        cmd.op    = CMD_FAIL;
                        cmd.err   = ERR_NO_ENDMARK;
                    end
                    PH_LENGTH:
                    begin
                        cmd_valid = 1'b1;
                        cmd.op    = CMD_FAIL;
                        cmd.err   = ERR_TRUNC_LEN;
                    end
                    PH_PAYLOAD:
                    begin
                        cmd_valid = 1'b1;
                        cmd.op    = CMD_FAIL;
                        cmd.err   = ERR_RANGE;
                    end
                    PH_ENDSEEN:
                    begin
                        cmd_valid       = 1'b1;
                        cmd.op          = CMD_OK;
                        cmd.block_type  = 4'd0;
                    end
                    default:
                    begin
                    end
                endcase
                phase_next = PH_HALT;
            end
            else
            begin
                unique case (phase_reg)
                    PH_MARKER:
                    begin
                        type_next      = data_byte[3:0];
                        cmd.block_type = data_byte[3:0];
                        if (data_byte[3:0] == END_TYPE)
                        begin
                            cmd_valid  = 1'b1;
                            cmd.op     = CMD_ENDMARK;
                            phase_next = PH_ENDSEEN;
                        end
                        else if (code < 4'(MAX_LENGTH_BYTES))
                        begin
                            len_left_next = LEN_CNT_W'(code) + LEN_CNT_W'(1);
                            acc_next      = '0;
                            phase_next    = PH_LENGTH;
                        end
                        else
                        begin
                            start_blk = 1'b1;
                            blk_len   = LEN_W'(code - 4'(MAX_LENGTH_BYTES));
                        end
                    end
                    PH_LENGTH:
                    begin
                        acc_next = {acc_reg[LEN_W-9:0], data_byte};
                        if (len_left_reg != '0)
                            len_left_next = len_left_reg - LEN_CNT_W'(1);
                        if (len_left_next == '0)
                        begin
                            start_blk = 1'b1;
                            blk_len   = acc_next;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        if (pay_left_reg != '0)
                            pay_left_next = pay_left_reg - LEN_W'(1);
                        cmd_valid = 1'b1;
                        cmd.op    = CMD_BYTE;
                        cmd.data  = LEN_W'(data_byte);
                        cmd.last  = (pay_left_next == '0);
                        if (pay_left_next == '0)
                            phase_next = PH_MARKER;
                    end
                    default:
                    begin
                    end
                endcase

                // Header complete: hand the length to the back end
                if (start_blk)
                begin
                    cmd_valid     = 1'b1;
                    cmd.op        = CMD_BLOCK;
                    cmd.data      = blk_len;
                    pay_left_next = blk_len;
                    phase_next    = (blk_len == '0) ? PH_MARKER : PH_PAYLOAD;
                end
            end
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MARKER;
            type_reg     <= '0;
            len_left_reg <= '0;
            acc_reg      <= '0;
            pay_left_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            type_reg     <= type_next;
            len_left_reg <= len_left_next;
            acc_reg      <= acc_next;
            pay_left_reg <= pay_left_next;
        end
    end

endmodule

FILE: sv/tbd_queue.sv
// ----------------------------------------------------------------------------
// Tagged block deframer command queue
// Small FIFO, parser to back end; push and pop can share a cycle unless full or empty.
// ----------------------------------------------------------------------------
module tbd_queue
    import tbd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

FILE: sv/tbd_back.sv
// ----------------------------------------------------------------------------
// Tagged block deframer back end
// Executes each command, applies the byte and block limits, drives the result.
// ----------------------------------------------------------------------------
module tbd_back
    import tbd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   q_empty,
    input  cmd_t                   q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             kind,
    output logic [3:0]             block_type,
    output logic [7:0]             payload_byte,
    output logic                   last_in_block,
    output logic [1:0]             fault_code
);

    logic [CFG_DATA_W-1:0] max_total_reg;
    logic [CFG_DATA_W-1:0] max_blocks_reg;
    logic                  halt_reg, halt_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic [CNT_W-1:0]      blocks_reg, blocks_next;
    logic                  out_valid_reg;
    logic [2:0]            kind_reg, kind_next;
    logic [3:0]            type_reg, type_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  last_reg, last_next;
    logic [1:0]            err_reg, err_next;
    logic                  emit;

    logic [CNT_W:0]        room;
    logic                  range_bad;
    logic [CNT_W-1:0]      blocks_inc;
    logic                  too_many;

    assign q_pop = !q_empty && (!out_valid_reg || !out_stall);

    // Headroom left under the byte limit; negative headroom never trips
    assign room      = {2'b00, max_total_reg} - {1'b0, total_reg};
    assign range_bad = !room[CNT_W] && ({2'b00, q_data.data} > room);
    assign blocks_inc = blocks_reg + CNT_W'(1);
    assign too_many   = blocks_inc > {1'b0, max_blocks_reg};

    // Command execution
    always_comb
    begin
        halt_next   = halt_reg;
        total_next  = total_reg;
        blocks_next = blocks_reg;
        emit        = 1'b0;
        kind_next   = KIND_PAYLOAD;
        type_next   = q_data.block_type;
        byte_next   = 8'd0;
        last_next   = 1'b0;
        err_next    = ERR_TRUNC_LEN;

        if (q_pop && !halt_reg)
        begin
            unique case (q_data.op)
                CMD_BLOCK:
                begin
                    if (range_bad)
                    begin
                        emit      = 1'b1;
                        kind_next = KIND_ERROR;
                        err_next  = ERR_RANGE;
                        halt_next = 1'b1;
                    end
                    else
                    begin
                        total_next = total_reg + CNT_W'(q_data.data);
                        if (q_data.data == '0)
                        begin
                            blocks_next = blocks_inc;
                            emit        = 1'b1;
                            if (too_many)
                            begin
                                kind_next = KIND_ERROR;
                                err_next  = ERR_TOO_MANY;
                                halt_next = 1'b1;
                            end
                            else
                                kind_next = KIND_EMPTY;
                        end
                    end
                end
                CMD_BYTE:
                begin
                    emit = 1'b1;
                    if (q_data.last)
                        blocks_next = blocks_inc;
                    if (q_data.last && too_many)
                    begin
                        kind_next = KIND_ERROR;
                        err_next  = ERR_TOO_MANY;
                        halt_next = 1'b1;
                    end
                    else
                    begin
                        kind_next = KIND_PAYLOAD;
                        byte_next = q_data.data[7:0];
                        last_next = q_data.last;
                    end
                end
                CMD_ENDMARK:
                begin
                    emit      = 1'b1;
                    kind_next = KIND_ENDMARK;
                end
                CMD_FAIL:
                begin
                    emit      = 1'b1;
                    kind_next = KIND_ERROR;
                    err_next  = q_data.err;
                    halt_next = 1'b1;
                end
                CMD_OK:
                begin
                    emit      = 1'b1;
                    kind_next = KIND_OK;
                    type_next = 4'd0;
                    halt_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_total_reg  <= MAX_TOTAL_RESET;
            max_blocks_reg <= MAX_BLOCKS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MAX_TOTAL_BYTES: max_total_reg  <= cfg_data;
                REG_MAX_BLOCKS:      max_blocks_reg <= cfg_data;
            endcase
        end
    end

    // Running totals and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_reg      <= 1'b0;
            total_reg     <= '0;
            blocks_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            halt_reg   <= halt_next;
            total_reg  <= total_next;
            blocks_reg <= blocks_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg <= kind_next;
            type_reg <= type_next;
            byte_reg <= byte_next;
            last_reg <= last_next;
            err_reg  <= err_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign block_type    = type_reg;
    assign payload_byte  = byte_reg;
    assign last_in_block = last_reg;
    assign fault_code    = err_reg;

endmodule

FILE: sv/tagged_block_deframer.sv
// ----------------------------------------------------------------------------
// Tagged block deframer
// Splits a byte stream into typed blocks and emits tagged payload bytes.
// ----------------------------------------------------------------------------
// The block takes one stream byte or end-of-stream per clock while in_stall
// is low and gives at most one result per item. The parser writes a command
// into a two-entry queue at the accepting edge; the back end pops it while
// the output is not stalled, applies the byte and block limits and loads the
// output register. Sustained rate is one item per cycle when the output does
// not stall, set by the single-byte parser step; in_stall rises only when
// the queue is full, that is when the output has been stalled. A byte that
// completes the header of a nonempty block writes a command that makes no
// result unless the block breaks the byte limit, and holds a queue slot
// until the back end takes it; marker bytes that open a length field, length
// bytes before the last and ignored bytes write nothing. Configuration
// writes go to the back end and must be made while the block is idle.
module tagged_block_deframer
    import tbd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   operation,
    input  logic [7:0]             data_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             kind,
    output logic [3:0]             block_type,
    output logic [7:0]             payload_byte,
    output logic                   last_in_block,
    output logic [1:0]             fault_code
);

    logic accept;
    logic cmd_valid;
    cmd_t cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    cmd_t q_data;

    // Input transfer
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    tbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (operation),
        .data_byte (data_byte),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    tbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_valid),
        .push_data (cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    tbd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_empty       (q_empty),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .block_type    (block_type),
        .payload_byte  (payload_byte),
        .last_in_block (last_in_block),
        .fault_code    (fault_code)
    );

endmodule

FILE: tb/sv/tb_tagged_block_deframer.sv
// ----------------------------------------------------------------------------
// Tagged block deframer testbench
// Sends a single long byte stream to the deframer. The stream opens with a
// few hand-picked blocks, then runs random well-formed blocks in phases.
// Each phase has its own byte and block limits, including exact-fit,
// below-total and maximum settings. The stream closes with one randomly chosen
// ending: a clean end, an early end of stream, a range fault or a block-count
// fault. That ending is followed by ignored noise. An in-bench predictor keeps
// the expected results in order, and a monitor compares each output transfer
// field by field.
// ----------------------------------------------------------------------------
module tb_tagged_block_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    import tbd_pkg::*;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam int         ITEM_GOAL  = 1800;
    localparam int         STALL_MAX  = 19;
    localparam int         IDLE_LIMIT = 1000;
    localparam int         PRINT_MAX  = 100;

    typedef struct packed {
        logic       op;
        logic [7:0] b;
    } stream_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] btype;
        logic [7:0] pbyte;
        logic       last;
        logic [1:0] err;
    } frame_result_t;

    typedef enum logic [2:0] {
        WAIT_MARKER,
        IN_LENGTH,
        IN_PAYLOAD,
        AFTER_END,
        STOPPED
    } parse_state_t;

    typedef enum int {
        FIN_OK,
        FIN_EOS_MARKER,
        FIN_EOS_LENGTH,
        FIN_EOS_PAYLOAD,
        FIN_RANGE,
        FIN_COUNT
    } stream_finish_t;

    // DUT connections
    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_write     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   in_valid      = 1'b0;
    logic                   in_stall;
    logic                   operation     = OP_BYTE;
    logic [7:0]             data_byte     = 8'd0;
    logic                   out_valid;
    logic                   out_stall     = 1'b0;
    logic [2:0]             kind;
    logic [3:0]             block_type;
    logic [7:0]             payload_byte;
    logic                   last_in_block;
    logic [1:0]             fault_code;

    // Stimulus and scoreboard state
    stream_item_t  stream_items[$];
    frame_result_t expected_out[$];
    bit            in_taken    = 1'b0;
    bit            no_gaps     = 1'b0;
    int            in_gap      = 0;
    int            out_hold    = 0;
    int            mismatches  = 0;
    int            items_made  = 0;
    int            idle_cycles = 0;

    // Predictor state and its copy of the limits
    parse_state_t  ps          = WAIT_MARKER;
    logic [3:0]    cur_type    = 4'd0;
    logic [2:0]    len_left    = 3'd0;
    logic [31:0]   len_acc     = 32'd0;
    logic [31:0]   pay_left    = 32'd0;
    logic [63:0]   total_bytes = 64'd0;
    logic [63:0]   block_cnt   = 64'd0;
    logic [31:0]   lim_total   = MAX_TOTAL_RESET;
    logic [31:0]   lim_blocks  = MAX_BLOCKS_RESET;

    tagged_block_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .block_type    (block_type),
        .payload_byte  (payload_byte),
        .last_in_block (last_in_block),
        .fault_code    (fault_code)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void expect_result(logic [2:0] k, logic [3:0] t, logic [7:0] pb,
                                          logic l, logic [1:0] e);
        frame_result_t r;
        r.kind  = k;
        r.btype = t;
        r.pbyte = pb;
        r.last  = l;
        r.err   = e;
        expected_out.insert(expected_out.size(), r);
    endfunction

    function automatic void halt_with(logic [1:0] e);
        ps = STOPPED;
        expect_result(KIND_ERROR, cur_type, 8'd0, 1'b0, e);
    endfunction

    // count a finished block; returns 1 when the block limit is exceeded
    function automatic logic close_block();
        block_cnt = block_cnt + 64'd1;
        ps = WAIT_MARKER;
        return block_cnt > {32'd0, lim_blocks};
    endfunction

    function automatic void open_block(logic [31:0] length);
        logic [63:0] room;
        // unsigned 64-bit room: wraps huge when the limit sits below the total
        room = {32'd0, lim_total} - total_bytes;
        if ({32'd0, length} > room)
            halt_with(ERR_RANGE);
        else
        begin
            total_bytes = total_bytes + {32'd0, length};
            if (length == 32'd0)
            begin
                if (close_block())
                    halt_with(ERR_TOO_MANY);
                else
                    expect_result(KIND_EMPTY, cur_type, 8'd0, 1'b0, ERR_NONE);
            end
            else
            begin
                pay_left = length;
                ps = IN_PAYLOAD;
            end
        end
    endfunction

    function automatic void deframe_step(logic op, logic [7:0] b);
        if (op == OP_END)
        begin
            case (ps)
                WAIT_MARKER: halt_with(ERR_NO_ENDMARK);
                IN_LENGTH:   halt_with(ERR_TRUNC_LEN);
                IN_PAYLOAD:  halt_with(ERR_RANGE);
                AFTER_END:
                begin
                    ps = STOPPED;
                    expect_result(KIND_OK, 4'd0, 8'd0, 1'b0, ERR_NONE);
                end
                default: ;
            endcase
        end
        else
        begin
            case (ps)
                WAIT_MARKER:
                begin
                    cur_type = b[3:0];
                    if (cur_type == END_TYPE)
                    begin
                        ps = AFTER_END;
                        expect_result(KIND_ENDMARK, cur_type, 8'd0, 1'b0, ERR_NONE);
                    end
                    else if (int'(b[7:4]) < MAX_LENGTH_BYTES)
                    begin
                        len_left = 3'(b[7:4] + 4'd1);
                        len_acc = 32'd0;
                        ps = IN_LENGTH;
                    end
                    else
                        open_block(32'(b[7:4]) - 32'(MAX_LENGTH_BYTES));
                end
                IN_LENGTH:
                begin
                    len_acc = {len_acc[23:0], b};
                    if (len_left > 3'd0)
                        len_left = len_left - 3'd1;
                    if (len_left == 3'd0)
                        open_block(len_acc);
                end
                IN_PAYLOAD:
                begin
                    if (pay_left > 32'd0)
                        pay_left = pay_left - 32'd1;
                    if (pay_left == 32'd0)
                    begin
                        if (close_block())
                            halt_with(ERR_TOO_MANY);
                        else
                            expect_result(KIND_PAYLOAD, cur_type, b, 1'b1, ERR_NONE);
                    end
                    else
                        expect_result(KIND_PAYLOAD, cur_type, b, 1'b0, ERR_NONE);
                end
                default: ;
            endcase
        end
    endfunction

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    function automatic int draw_wait();
        return no_gaps ? 0 : int'($urandom_range(0, STALL_MAX));
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= PRINT_MAX)
            $display("tb_tagged_block_deframer: mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic void put_item(logic op, logic [7:0] b);
        stream_item_t it;
        it.op = op;
        it.b  = b;
        stream_items.insert(stream_items.size(), it);
        items_made++;
    endfunction

    function automatic void put_byte(logic [7:0] b);
        put_item(OP_BYTE, b);
    endfunction

    function automatic logic [3:0] pick_type();
        logic [3:0] t;
        do
            t = 4'($urandom);
        while (t == END_TYPE);
        return t;
    endfunction

    // header for a block of len bytes, short or length-field form, then npay bytes
    function automatic void put_block(logic [3:0] t, int unsigned len, int unsigned npay);
        int          nlen;
        logic [31:0] lv;
        lv = len;
        if (len <= 11 && $urandom_range(0, 1) == 1)
            put_byte({4'(len + 4), t});
        else
        begin
            nlen = $urandom_range(1, MAX_LENGTH_BYTES);
            put_byte({4'(nlen - 1), t});
            for (int i = nlen - 1; i >= 0; i--)
                put_byte(lv[8*i +: 8]);
        end
        repeat (npay)
            put_byte(8'($urandom));
    endfunction

    // idle: nothing pending, nothing in flight, then a wait for header bytes
    // still passing through the block
    task automatic wait_idle();
        do
            @(posedge clk);
        while (stream_items.size() != 0 || in_valid || expected_out.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limits(logic [31:0] total_lim, logic [31:0] blocks_lim);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_MAX_TOTAL_BYTES;
        cfg_data  <= total_lim;
        @(negedge clk);
        cfg_index <= REG_MAX_BLOCKS;
        cfg_data  <= blocks_lim;
        @(negedge clk);
        cfg_write <= 1'b0;
        lim_total  = total_lim;
        lim_blocks = blocks_lim;
    endtask

    // ------------------------------------------------------------------------
    // Input side: acceptance at the rising edge, drive at the falling edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            deframe_step(operation, data_byte);
            in_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin : drive_stream
        logic         next_valid;
        stream_item_t it;
        next_valid = in_valid;
        if (!in_valid || in_taken)
        begin
            if (in_taken)
            begin
                in_taken = 1'b0;
                in_gap = draw_wait();
            end
            next_valid = 1'b0;
            if (in_gap > 0)
                in_gap--;
            else if (stream_items.size() > 0)
            begin
                it = stream_items.pop_front();
                operation <= it.op;
                data_byte <= it.b;
                next_valid = 1'b1;
            end
        end
        in_valid <= next_valid;
    end

    // ------------------------------------------------------------------------
    // Output side: check each transfer, maybe stall before the next one
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            out_hold = draw_wait();
            if (expected_out.size() == 0)
                report_mismatch($sformatf("unexpected result kind %0d", kind));
            else
            begin
                want = expected_out.pop_front();
                if (kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
                if (block_type !== want.btype)
                    report_mismatch($sformatf("block_type %0d, expected %0d",
                                              block_type, want.btype));
                if (payload_byte !== want.pbyte)
                    report_mismatch($sformatf("payload_byte %0h, expected %0h",
                                              payload_byte, want.pbyte));
                if (last_in_block !== want.last)
                    report_mismatch($sformatf("last_in_block %0b, expected %0b",
                                              last_in_block, want.last));
                if (fault_code !== want.err)
                    report_mismatch($sformatf("fault_code %0d, expected %0d",
                                              fault_code, want.err));
            end
        end
    end

    always @(negedge clk)
    begin
        if (out_hold > 0)
        begin
            out_stall <= 1'b1;
            out_hold--;
        end
        else
            out_stall <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any transfer
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_tagged_block_deframer: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned    lens[16];
        int unsigned    nblk;
        int unsigned    sum;
        int unsigned    pick;
        int unsigned    len;
        logic [3:0]     code;
        logic [31:0]    tot_lim;
        logic [31:0]    blk_lim;
        stream_finish_t fin;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // hand-picked blocks under reset limits
        put_byte(8'h41);                          // empty, short form
        put_byte(8'h5F);                          // type 15, one byte
        put_byte(8'hAB);
        put_byte(8'h00);                          // one-byte length field
        put_byte(8'h02);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h3E);                          // four-byte length field
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h01);
        put_byte(8'h55);
        wait_idle();

        // zero byte budget: only empty blocks get through
        write_limits(32'd0, 32'hFFFF_FFFF);
        put_byte(8'h29);                          // three-byte zero length
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h4C);
        put_byte(8'h10);                          // two-byte zero length
        put_byte(8'h00);
        put_byte(8'h00);
        wait_idle();

        // random phases of well-formed blocks, each with its own limits
        while (items_made < ITEM_GOAL)
        begin
            nblk = $urandom_range(4, 16);
            sum = 0;
            for (int i = 0; i < nblk; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    lens[i] = $urandom_range(0, 6);
                else if (pick < 95)
                    lens[i] = $urandom_range(7, 20);
                else
                    lens[i] = $urandom_range(21, 60);
                sum += lens[i];
            end
            case ($urandom_range(0, 9))
                0, 1: write_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2, 3: write_limits(32'(total_bytes) + sum, 32'(block_cnt) + nblk);
                4:
                begin
                    // limit below the bytes so far, else an exact block limit
                    if (total_bytes > 0)
                        write_limits($urandom_range(0, 32'(total_bytes) - 1), 32'hFFFF_FFFF);
                    else
                        write_limits(32'hFFFF_FFFF, 32'(block_cnt) + nblk);
                end
                default: write_limits(32'(total_bytes) + sum + $urandom_range(0, 5000),
                                      32'(block_cnt) + nblk + $urandom_range(0, 100));
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < nblk; i++)
                put_block(pick_type(), lens[i], lens[i]);
            wait_idle();
        end

        // one ending per run; the block stops for good after it
        no_gaps = 1'b0;
        fin = stream_finish_t'($urandom_range(FIN_OK, FIN_COUNT));
        tot_lim = 32'hFFFF_FFFF;
        blk_lim = 32'hFFFF_FFFF;
        len = $urandom_range(1, 20);
        if (fin == FIN_RANGE && (total_bytes == 0 || $urandom_range(0, 1) == 1))
        begin
            pick = $urandom_range(0, 30);
            tot_lim = 32'(total_bytes) + pick;
            len = pick + $urandom_range(1, 20);
        end
        else if (fin == FIN_COUNT)
        begin
            blk_lim = 32'(block_cnt);
            len = $urandom_range(0, 5);
        end
        write_limits(tot_lim, blk_lim);
        case (fin)
            FIN_OK:
            begin
                put_byte({4'($urandom), END_TYPE});
                repeat ($urandom_range(0, 5))
                    put_byte(8'($urandom));
                put_item(OP_END, 8'($urandom));
            end
            FIN_EOS_MARKER:
                put_item(OP_END, 8'($urandom));
            FIN_EOS_LENGTH:
            begin
                code = 4'($urandom_range(0, MAX_LENGTH_BYTES - 1));
                put_byte({code, pick_type()});
                repeat ($urandom_range(0, code))
                    put_byte(8'($urandom));
                put_item(OP_END, 8'($urandom));
            end
            FIN_EOS_PAYLOAD:
            begin
                put_block(pick_type(), len, $urandom_range(0, len - 1));
                put_item(OP_END, 8'($urandom));
            end
            FIN_RANGE:
            begin
                if (tot_lim == 32'hFFFF_FFFF)
                begin
                    // largest length field against the largest limit
                    put_byte({4'(MAX_LENGTH_BYTES - 1), pick_type()});
                    repeat (MAX_LENGTH_BYTES)
                        put_byte(8'hFF);
                end
                else
                    put_block(pick_type(), len, 0);
            end
            default:
                put_block(pick_type(), len, len);
        endcase

        // ignored tail
        repeat (30)
            put_item(1'($urandom), 8'($urandom));
        wait_idle();
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("tb_tagged_block_deframer: done, clean");
        else
            $display("tb_tagged_block_deframer: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
sv/tbd_pkg.sv
sv/tbd_front.sv
sv/tbd_queue.sv
sv/tbd_back.sv
sv/tagged_block_deframer.sv
tb/sv/tb_tagged_block_deframer.sv
